// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define HISC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HISC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hisc_pkg.sv =====
// Package with shared types, codes and the character classifier.
package hisc_pkg;

    // Field widths.
    localparam int unsigned CH_W     = 8;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned DIG_W    = 2;
    localparam int unsigned OCTET_W  = 8;

    // Item command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MAX_LABEL = 1'b0;
    localparam logic CFG_MIN_TLD   = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0] MAX_LABEL_RST = 6'd63;
    localparam logic [LEN_W-1:0] MIN_TLD_RST   = 6'd2;

    // Dotted quad limits.
    localparam logic [CNT_W-1:0] OCTET_CNT_SAT  = 3'd5;
    localparam logic [CNT_W-1:0] OCTET_CNT_DOTS = 3'd3;
    localparam logic [DIG_W-1:0] OCTET_DIG_MAX  = 2'd3;
    localparam logic [11:0]      OCTET_VAL_MAX  = 12'd255;

    // Characters of interest.
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;

    // Class of one character, plus its digit value.
    typedef struct packed {
        logic             is_digit;
        logic             is_dot;
        logic             is_letter;
        logic             is_hyphen;
        logic [3:0]       digit;
    } t_char_cls;

    // Per-item control from the top level to the trackers.
    typedef struct packed {
        logic upd;
        logic clr;
    } t_step_ctl;

    function automatic t_char_cls hisc_classify(input logic [CH_W-1:0] c);
        t_char_cls r;
        logic [CH_W-1:0] off;
        off         = c - CH_ZERO;
        r.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        r.is_dot    = (c == CH_DOT);
        r.is_hyphen = (c == CH_HYPHEN);
        r.is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                      ((c >= CH_LO_A) && (c <= CH_LO_Z));
        r.digit     = off[3:0];
        return r;
    endfunction

endpackage

// ===== rtl/hisc_quad.sv =====
// Dotted quad tracker: octet count, digit count and value of the current octet.
`include "assert_macros.svh"
module hisc_quad
    import hisc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_ctl i_ctl,
    input  t_char_cls i_cls,
    output logic      o_quad_ok
);

    logic               r_failed, n_failed;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DIG_W-1:0]   r_digits, n_digits;
    logic [OCTET_W-1:0] r_value, n_value;
    logic [11:0]        w_next_val;

    // Value of the octet if the current digit is appended.
    assign w_next_val = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0} +
                        {8'h00, i_cls.digit};

    // Per-character update of the quad state.
    always_comb begin
        n_failed = r_failed;
        n_count  = r_count;
        n_digits = r_digits;
        n_value  = r_value;
        if (i_ctl.upd && !r_failed) begin
            if (i_cls.is_digit) begin
                if ((r_digits >= OCTET_DIG_MAX) || (w_next_val > OCTET_VAL_MAX)) begin
                    n_failed = 1'b1;
                end else begin
                    n_digits = r_digits + 2'd1;
                    n_value  = w_next_val[OCTET_W-1:0];
                end
            end else if (i_cls.is_dot) begin
                if (r_digits == '0) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_count < OCTET_CNT_SAT) begin
                        n_count = r_count + 3'd1;
                    end
                    n_digits = '0;
                    n_value  = '0;
                end
            end else begin
                n_failed = 1'b1;
            end
        end
    end

    // State registers, cleared by reset and after every end item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_failed <= 1'b0;
            r_count  <= '0;
            r_digits <= '0;
            r_value  <= '0;
        end else begin
            r_failed <= n_failed;
            r_count  <= n_count;
            r_digits <= n_digits;
            r_value  <= n_value;
        end
    end

    // Exactly four complete octets means three dots and a digit after the last.
    assign o_quad_ok = !r_failed && (r_digits != '0) && (r_count == OCTET_CNT_DOTS);

    // An octet with no digits yet always has a zero value.
    `HISC_ASSERT(a_empty_octet_zero, i_clk, i_rst_n, (r_digits == '0) |-> (r_value == '0), "octet value without digits")

endmodule

// ===== rtl/hisc_host.sv =====
// Hostname tracker: label length, letter count, dot and hyphen flags.
`include "assert_macros.svh"
module hisc_host
    import hisc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step_ctl        i_ctl,
    input  t_char_cls        i_cls,
    input  logic [LEN_W-1:0] i_max_label_len,
    input  logic [LEN_W-1:0] i_min_tld_len,
    output logic             o_host_ok
);

    logic             r_failed, n_failed;
    logic             r_seen_dot, n_seen_dot;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_letters, n_letters;
    logic             r_prev_hyphen, n_prev_hyphen;

    // Per-character update of the hostname state.
    always_comb begin
        n_failed      = r_failed;
        n_seen_dot    = r_seen_dot;
        n_len         = r_len;
        n_letters     = r_letters;
        n_prev_hyphen = r_prev_hyphen;
        if (i_ctl.upd && !r_failed) begin
            if (i_cls.is_dot) begin
                if ((r_len == '0) || r_prev_hyphen) begin
                    n_failed = 1'b1;
                end else begin
                    n_seen_dot    = 1'b1;
                    n_len         = '0;
                    n_letters     = '0;
                    n_prev_hyphen = 1'b0;
                end
            end else if (i_cls.is_letter || i_cls.is_digit) begin
                if (r_len >= i_max_label_len) begin
                    n_failed = 1'b1;
                end else begin
                    n_len         = r_len + 6'd1;
                    n_prev_hyphen = 1'b0;
                    if (i_cls.is_letter) begin
                        n_letters = r_letters + 6'd1;
                    end
                end
            end else if (i_cls.is_hyphen) begin
                if ((r_len == '0) || (r_len >= i_max_label_len)) begin
                    n_failed = 1'b1;
                end else begin
                    n_len         = r_len + 6'd1;
                    n_prev_hyphen = 1'b1;
                end
            end else begin
                n_failed = 1'b1;
            end
        end
    end

    // State registers, cleared by reset and after every end item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_failed      <= 1'b0;
            r_seen_dot    <= 1'b0;
            r_len         <= '0;
            r_letters     <= '0;
            r_prev_hyphen <= 1'b0;
        end else begin
            r_failed      <= n_failed;
            r_seen_dot    <= n_seen_dot;
            r_len         <= n_len;
            r_letters     <= n_letters;
            r_prev_hyphen <= n_prev_hyphen;
        end
    end

    // The name needs a dot, and the last label must be non-empty, all letters and long enough.
    assign o_host_ok = !r_failed && (r_len != '0) && !r_prev_hyphen && r_seen_dot &&
                       (r_len >= i_min_tld_len) && (r_letters == r_len);

    // A trailing hyphen is only ever recorded inside a started label.
    `HISC_ASSERT(a_hyphen_in_label, i_clk, i_rst_n, r_prev_hyphen |-> (r_len != '0), "hyphen flag with empty label")

endmodule

// ===== rtl/hostname_ipv4_syntax_check.sv =====
// Top level of the hostname and IPv4 dotted quad syntax checker.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_cmd, i_ch
// result    out        o_valid / i_stall         o_valid_res, o_numeric_form
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is taken per clock unless the input stalls; a character item updates the
// trackers in the cycle after it is accepted, through the input register.
// An end item's verdict is written to the result register at the edge where the
// item leaves the input register, which a result register still full can delay.
// Reset is synchronous and active low; it restores both configuration registers
// and clears all string state.
// The input stalls only while an end item waits in the input register and the
// result register still holds a verdict that is not taken.
`include "assert_macros.svh"
module hostname_ipv4_syntax_check
    import hisc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_cmd,
    input  logic [CH_W-1:0]  i_ch,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_valid_res,
    output logic             o_numeric_form,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    logic             r_in_cmd;
    logic [CH_W-1:0]  r_in_ch;
    logic             r_out_valid;
    logic             r_out_res;
    logic             r_out_num;
    logic             r_only_dd, n_only_dd;
    logic [LEN_W-1:0] r_max_label_len;
    logic [LEN_W-1:0] r_min_tld_len;
    logic             w_out_free;
    logic             w_consume;
    logic             w_take_in;
    logic             w_quad_ok;
    logic             w_host_ok;
    t_char_cls        w_cls;
    t_step_ctl        w_ctl;

    // Handshake: the stored item leaves unless it is an end item facing a full slot.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_consume  = r_in_valid && ((r_in_cmd == CMD_CHAR) || w_out_free);
    assign o_stall    = r_in_valid && !w_consume;
    assign w_take_in  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take_in || w_consume) begin
            r_in_valid <= w_take_in;
        end
        if (w_take_in) begin
            r_in_cmd <= i_cmd;
            r_in_ch  <= i_ch;
        end
    end

    // Classification and tracker control for the stored item.
    assign w_cls     = hisc_classify(r_in_ch);
    assign w_ctl.upd = w_consume && (r_in_cmd == CMD_CHAR);
    assign w_ctl.clr = w_consume && (r_in_cmd == CMD_END);

    hisc_quad u_quad (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cls     (w_cls),
        .o_quad_ok (w_quad_ok)
    );

    hisc_host u_host (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_cls           (w_cls),
        .i_max_label_len (r_max_label_len),
        .i_min_tld_len   (r_min_tld_len),
        .o_host_ok       (w_host_ok)
    );

    // Digits-and-dots flag picks which check gives the verdict.
    always_comb begin
        n_only_dd = r_only_dd;
        if (w_ctl.upd && !(w_cls.is_digit || w_cls.is_dot)) begin
            n_only_dd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.clr) begin
            r_only_dd <= 1'b1;
        end else begin
            r_only_dd <= n_only_dd;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.clr) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_ctl.clr) begin
            r_out_res <= r_only_dd ? w_quad_ok : w_host_ok;
            r_out_num <= r_only_dd;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_valid_res    = r_out_res;
    assign o_numeric_form = r_out_num;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_label_len <= MAX_LABEL_RST;
            r_min_tld_len   <= MIN_TLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_LABEL: r_max_label_len <= i_cfg_data;
                CFG_MIN_TLD:   r_min_tld_len   <= i_cfg_data;
                default:       r_max_label_len <= r_max_label_len;
            endcase
        end
    end

    // A new verdict appears only after an end item left the input register.
    `HISC_ASSERT(a_result_from_end, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_ctl.clr), "result without end item")
    // Input back-pressure comes only from a blocked end item.
    `HISC_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (r_in_cmd == CMD_END && r_out_valid && i_stall), "unexpected input stall")

endmodule
